// ===== rtl/cmo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cmo_pkg;

    // Sizes of the oscillator bank and the cadence
    localparam int OSC_COUNT  = 4;
    localparam int OSC_W      = 2;
    localparam int SEG_COUNT  = 8;
    localparam int SEG_W      = 3;
    localparam int MAX_BLOCK  = 64;
    localparam int LEN_W      = 7;
    localparam int SMP_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SEG_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEATS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TONES     = 3'd5;

    // Request kinds
    localparam logic KIND_START    = 1'b0;
    localparam logic KIND_GENERATE = 1'b1;

    // Markers and limits
    localparam logic [15:0] ENDLESS  = 16'hFFFF;
    localparam logic [3:0]  BASE_MAX = 4'hF;

    // Issue of one oscillator slot to the resonator unit
    typedef struct packed {
        logic             valid;
        logic             act;
        logic [OSC_W-1:0] k;
    } cmo_issue_t;

    // Finished resonator step
    typedef struct packed {
        logic             valid;
        logic             act;
        logic [SMP_W-1:0] value;
    } cmo_result_t;

endpackage

`default_nettype wire

// ===== rtl/cmo_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface cmo_in_if;
    import cmo_pkg::*;

    logic             valid;
    logic             ready;
    logic             kind;
    logic [LEN_W-1:0] block_len;

    modport source (output valid, output kind, output block_len, input ready);
    modport sink (input valid, input kind, input block_len, output ready);
endinterface

`default_nettype wire

// ===== rtl/cmo_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface cmo_out_if;
    import cmo_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample;
    logic                    last;
    logic                    finished;

    modport source (output valid, output sample, output last, output finished, input ready);
    modport sink (input valid, input sample, input last, input finished, output ready);
endinterface

`default_nettype wire

// ===== rtl/cmo_resonator.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmo_resonator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic [cmo_pkg::CFG_DATA_W-1:0]      start_levels,
    input  logic [cmo_pkg::CFG_DATA_W-1:0]      coefs,
    input  cmo_pkg::cmo_issue_t                 issue,
    output cmo_pkg::cmo_result_t                result
);
    import cmo_pkg::*;

    localparam logic signed [33:0] SAT_POS = 34'sd2147483647;
    localparam logic signed [33:0] SAT_NEG = -34'sd2147483647;

    logic [SMP_W-1:0]        y1_reg [OSC_COUNT];
    logic [SMP_W-1:0]        y2_reg [OSC_COUNT];
    logic signed [31:0]      prod_reg;
    cmo_issue_t              p_reg;

    logic signed [SMP_W-1:0] y1_s;
    logic signed [SMP_W-1:0] coef_s;
    logic [SMP_W-1:0]        y2_p;
    logic signed [33:0]      acc;
    logic signed [33:0]      acc_sat;
    logic [SMP_W-1:0]        q;

    // Stage one: one shared multiply of y1 by the coefficient
    assign y1_s   = $signed(y1_reg[issue.k]);
    assign coef_s = $signed(coefs[16*issue.k +: 16]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
        end
        else
        begin
            p_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= y1_s * coef_s;
    end

    // Stage two: double, subtract y2 scaled up, clamp and drop 15 bits
    assign y2_p = y2_reg[p_reg.k];

    always_comb
    begin
        acc = $signed({prod_reg[31], prod_reg, 1'b0})
            - $signed({{3{y2_p[15]}}, y2_p, 15'b0});
        if (acc > SAT_POS)
        begin
            acc_sat = SAT_POS;
        end
        else if (acc < SAT_NEG)
        begin
            acc_sat = SAT_NEG;
        end
        else
        begin
            acc_sat = acc;
        end
        q = acc_sat[30:15];
    end

    // Shift the history of the stepped oscillator, or reload on start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < OSC_COUNT; i++)
            begin
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
        end
        else if (load)
        begin
            for (int i = 0; i < OSC_COUNT; i++)
            begin
                y1_reg[i] <= '0;
                y2_reg[i] <= start_levels[16*i +: 16];
            end
        end
        else if (p_reg.valid && p_reg.act)
        begin
            y2_reg[p_reg.k] <= y1_reg[p_reg.k];
            y1_reg[p_reg.k] <= q;
        end
    end

    assign result.valid = p_reg.valid;
    assign result.act   = p_reg.act;
    assign result.value = q;

endmodule

`default_nettype wire

// ===== rtl/cadenced_multitone_oscillator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Start words give no output and leave the request port ready, since the sequencer stays idle.
// A generate word may first advance the cadence, then passes a setup state, then for each
// sample issues four slots through the single shared multiplier and folds the last step on emit.
// Output stalls hold the sequencer in its emit state and so lengthen the block.
// Reset is asynchronous and active low: control and history registers clear, the tone is
// finished until a start.

module cadenced_multitone_oscillator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cmo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cmo_pkg::CFG_DATA_W-1:0]    cfg_data,
    cmo_in_if.sink                            request,
    cmo_out_if.source                         tone
);
    import cmo_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADV   = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    // Configuration registers
    logic [63:0] seg_low_reg;
    logic [63:0] seg_high_reg;
    logic [63:0] coefs_reg;
    logic [63:0] levels_reg;
    logic [15:0] repeat_total_reg;
    logic [15:0] tones_reg;

    // Sequencer and cadence state
    logic [2:0]           state_reg, state_next;
    logic [SEG_W-1:0]     seg_reg, seg_next;
    logic [15:0]          sl_reg, sl_next;
    logic [3:0]           base_reg, base_next;
    logic [15:0]          rep_reg, rep_next;
    logic                 done_reg, done_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [OSC_COUNT-1:0] mask_reg, mask_next;
    logic [OSC_W-1:0]     k_reg, k_next;
    logic [5:0]           j_reg, j_next;
    logic [SMP_W-1:0]     sum_reg, sum_next;

    // Output word
    logic             out_valid_reg, out_valid_next;
    logic [SMP_W-1:0] out_sample_reg, out_sample_next;
    logic             out_last_reg, out_last_next;
    logic             out_fin_reg, out_fin_next;

    logic             accept;
    logic             load;
    logic             emit;
    logic             out_free;
    logic [SEG_W-1:0] seg_adv;
    logic [15:0]      dur_adv;
    logic [3:0]       num;
    logic [4:0]       base_end;
    logic [4:0]       base_sum;
    logic [15:0]      sl_dec;
    logic [SMP_W-1:0] sum_after;
    logic [LEN_W-1:0] len_clip;
    cmo_issue_t       issue;
    cmo_result_t      res;

    function automatic logic [15:0] dur_of(input logic [SEG_W-1:0] s,
                                           input logic [63:0] low,
                                           input logic [63:0] high);
        logic [63:0] word;
        word = s[2] ? high : low;
        return word[16*s[1:0] +: 16];
    endfunction

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_low_reg      <= '0;
            seg_high_reg     <= '0;
            coefs_reg        <= '0;
            levels_reg       <= '0;
            repeat_total_reg <= '0;
            tones_reg        <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SEG_LOW:  seg_low_reg      <= cfg_data;
                REG_SEG_HIGH: seg_high_reg     <= cfg_data;
                REG_COEFS:    coefs_reg        <= cfg_data;
                REG_LEVELS:   levels_reg       <= cfg_data;
                REG_REPEATS:  repeat_total_reg <= cfg_data[15:0];
                REG_TONES:    tones_reg        <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // Shared resonator unit
    cmo_resonator u_resonator (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .start_levels (levels_reg),
        .coefs        (coefs_reg),
        .issue        (issue),
        .result       (res)
    );

    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;
    assign load          = accept && (request.kind == KIND_START);
    assign out_free      = !out_valid_reg || tone.ready;

    // Clamp the block length
    assign len_clip = (request.block_len > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK)
                                                              : request.block_len;

    // Next segment of the cadence
    assign seg_adv = (seg_reg == SEG_W'(SEG_COUNT - 1)) ? '0 : seg_reg + 1'b1;
    assign dur_adv = dur_of(seg_adv, seg_low_reg, seg_high_reg);

    // Oscillator span of the current segment
    assign num      = tones_reg[4*seg_reg[2:1] +: 4];
    assign base_end = {1'b0, base_reg} + {1'b0, num};
    assign base_sum = base_end;
    assign sl_dec   = ({9'b0, len_reg} < sl_reg) ? sl_reg - {9'b0, len_reg} : '0;

    // Fold in the finished step of an active oscillator
    assign sum_after = (res.valid && res.act) ? sum_reg + res.value : sum_reg;

    assign issue.valid = (state_reg == S_RUN);
    assign issue.act   = mask_reg[k_reg];
    assign issue.k     = k_reg;

    assign emit = (state_reg == S_EMIT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        seg_next   = seg_reg;
        sl_next    = sl_reg;
        base_next  = base_reg;
        rep_next   = rep_reg;
        done_next  = done_reg;
        len_next   = len_reg;
        mask_next  = mask_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        sum_next   = sum_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (request.kind == KIND_START)
                    begin
                        seg_next  = '0;
                        base_next = '0;
                        rep_next  = repeat_total_reg;
                        sl_next   = seg_low_reg[15:0];
                        done_next = 1'b0;
                    end
                    else if (len_clip != '0)
                    begin
                        len_next = len_clip;
                        if (!done_reg && (sl_reg == '0))
                        begin
                            state_next = S_ADV;
                        end
                        else
                        begin
                            state_next = S_SETUP;
                        end
                    end
                end
            end

            // Step one segment a cycle, skipping empty ones but never segment 0
            S_ADV:
            begin
                seg_next = seg_adv;
                if ((seg_adv == '0) || (dur_adv != '0))
                begin
                    sl_next    = dur_adv;
                    state_next = S_SETUP;
                    if (seg_adv == '0)
                    begin
                        base_next = '0;
                        if (rep_reg != ENDLESS)
                        begin
                            if (rep_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rep_next = rep_reg - 1'b1;
                            end
                        end
                    end
                end
            end

            // Latch the sounding oscillators, then account for the whole block
            S_SETUP:
            begin
                for (int i = 0; i < OSC_COUNT; i++)
                begin
                    mask_next[i] = !done_reg && !seg_reg[0]
                                 && (5'(i) >= {1'b0, base_reg}) && (5'(i) < base_end);
                end
                if (!done_reg && (sl_reg != ENDLESS))
                begin
                    sl_next = sl_dec;
                    if ((sl_dec == '0) && !seg_reg[0])
                    begin
                        base_next = (base_sum > {1'b0, BASE_MAX}) ? BASE_MAX : base_sum[3:0];
                    end
                end
                k_next     = '0;
                j_next     = '0;
                sum_next   = '0;
                state_next = S_RUN;
            end

            S_RUN:
            begin
                sum_next = sum_after;
                k_next   = k_reg + 1'b1;
                if (k_reg == OSC_W'(OSC_COUNT - 1))
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                sum_next = sum_after;
                if (out_free)
                begin
                    sum_next = '0;
                    k_next   = '0;
                    j_next   = j_reg + 1'b1;
                    if ({1'b0, j_reg} == len_reg - 1'b1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RUN;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Load the output word when its slot is free
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        out_fin_next    = out_fin_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_sample_next = sum_after;
            out_last_next   = ({1'b0, j_reg} == len_reg - 1'b1);
            out_fin_next    = done_reg;
        end
        else if (tone.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seg_reg       <= '0;
            sl_reg        <= '0;
            base_reg      <= '0;
            rep_reg       <= '0;
            done_reg      <= 1'b1;
            len_reg       <= '0;
            mask_reg      <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_reg       <= seg_next;
            sl_reg        <= sl_next;
            base_reg      <= base_next;
            rep_reg       <= rep_next;
            done_reg      <= done_next;
            len_reg       <= len_next;
            mask_reg      <= mask_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
        out_fin_reg    <= out_fin_next;
    end

    assign tone.valid    = out_valid_reg;
    assign tone.sample   = $signed(out_sample_reg);
    assign tone.last     = out_last_reg;
    assign tone.finished = out_fin_reg;

`ifndef SYNTHESIS
    a_fin_silent: assert property (@(posedge clk) disable iff (!rst_n)
        tone.valid && tone.finished |-> tone.sample == '0)
        else $error("finished word carries a non-zero sample");

    a_adv_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADV |-> !done_reg)
        else $error("cadence advance while tone is finished");

    a_gen_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && request.kind == KIND_GENERATE && request.block_len != '0
        |=> !request.ready)
        else $error("generate word did not occupy the sequencer");

    a_res_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> state_reg == S_RUN || state_reg == S_EMIT)
        else $error("resonator step outside a sample");
`endif

endmodule

`default_nettype wire
